[design/fcpg_pkg.sv]
// Shared types, constants and the microcode table of the filled circle pixel generator.
package fcpg_pkg;

  localparam int MAX_RADIUS_DEF = 127;
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;
  localparam int STEP_W         = 4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CTR_X      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CTR_Y      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FG_COLOR   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACK_COLOR = 3'd4;

  typedef logic [STEP_W-1:0] step_t;

  // Datapath operations, one per control word
  typedef enum logic [2:0] {
    A_NOP,
    A_ACCEPT,
    A_START,
    A_SQR,
    A_DIFF,
    A_ROOT,
    A_ROUND,
    A_EMIT
  } act_e;

  // Jump conditions; a true condition loads the target, otherwise advance
  typedef enum logic [2:0] {
    J_NONE,
    J_ALWAYS,
    J_NO_IN,
    J_NOT_START,
    J_CNT_MORE,
    J_OUT_BUSY,
    J_ROW_END
  } jump_e;

  typedef struct packed {
    act_e  act;
    jump_e jmp;
    step_t target;
  } ucode_t;

  // Status flags the datapath returns to the sequencer
  typedef struct packed {
    logic start;
    logic cnt_more;
    logic out_busy;
    logic row_end;
  } status_t;

  // Program steps
  localparam step_t ST_IDLE     = 4'd0;
  localparam step_t ST_DISPATCH = 4'd1;
  localparam step_t ST_START    = 4'd2;
  localparam step_t ST_SQR      = 4'd3;
  localparam step_t ST_DIFF     = 4'd4;
  localparam step_t ST_ROOT     = 4'd5;
  localparam step_t ST_ROUND    = 4'd6;
  localparam step_t ST_CHECK    = 4'd7;
  localparam step_t ST_WAIT_OUT = 4'd8;
  localparam step_t ST_EMIT     = 4'd9;
  localparam step_t ST_BACK     = 4'd10;

  function automatic ucode_t ucode_rom(input step_t step);
    ucode_t w;
    case (step)
      ST_IDLE:     w = '{A_ACCEPT, J_NO_IN,     ST_IDLE};
      ST_DISPATCH: w = '{A_NOP,    J_NOT_START, ST_WAIT_OUT};
      ST_START:    w = '{A_START,  J_NONE,      ST_IDLE};
      ST_SQR:      w = '{A_SQR,    J_NONE,      ST_IDLE};
      ST_DIFF:     w = '{A_DIFF,   J_NONE,      ST_IDLE};
      ST_ROOT:     w = '{A_ROOT,   J_CNT_MORE,  ST_ROOT};
      ST_ROUND:    w = '{A_ROUND,  J_NONE,      ST_IDLE};
      ST_CHECK:    w = '{A_NOP,    J_NOT_START, ST_IDLE};
      ST_WAIT_OUT: w = '{A_NOP,    J_OUT_BUSY,  ST_WAIT_OUT};
      ST_EMIT:     w = '{A_EMIT,   J_ROW_END,   ST_SQR};
      ST_BACK:     w = '{A_NOP,    J_ALWAYS,    ST_IDLE};
      default:     w = '{A_NOP,    J_ALWAYS,    ST_IDLE};
    endcase
    return w;
  endfunction

endpackage

[design/fcpg_seq.sv]
// Microcode sequencer: step counter, control word fetch and conditional jumps.
module fcpg_seq (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  fcpg_pkg::status_t status,
  output fcpg_pkg::act_e    act,
  output logic              idle
);
  import fcpg_pkg::*;

  step_t  step;
  step_t  step_next;
  ucode_t word;
  logic   take;

  assign word = ucode_rom(step);
  assign act  = word.act;
  assign idle = (step == ST_IDLE);

  always_comb begin
    case (word.jmp)
      J_NONE:      take = 1'b0;
      J_ALWAYS:    take = 1'b1;
      J_NO_IN:     take = !in_valid;
      J_NOT_START: take = !status.start;
      J_CNT_MORE:  take = status.cnt_more;
      J_OUT_BUSY:  take = status.out_busy;
      J_ROW_END:   take = status.row_end;
      default:     take = 1'b1;
    endcase
    step_next = take ? word.target : step + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ST_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

[design/fcpg_datapath.sv]
// Datapath: configuration, raster offsets, integer root unit and output word register.
module fcpg_datapath #(
  parameter int MAX_RADIUS = fcpg_pkg::MAX_RADIUS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  fcpg_pkg::act_e                 act,
  input  logic                           cfg_we,
  input  logic [fcpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fcpg_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           in_valid,
  input  logic                           restart,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic [7:0]                     pixel_x,
  output logic [7:0]                     pixel_y,
  output logic [15:0]                    pixel_color,
  output logic                           last_pixel,
  output fcpg_pkg::status_t              status
);
  import fcpg_pkg::*;

  // Configuration
  logic [7:0]  ctr_x;
  logic [7:0]  ctr_y;
  logic [6:0]  radius;
  logic [15:0] fg_color;
  logic [15:0] back_color;

  // Raster state
  logic [7:0]  row;
  logic [7:0]  col;
  logic [7:0]  half_width;
  logic        done;
  logic        req_start;
  logic [6:0]  rs;

  // Root unit
  logic [13:0] rr;
  logic [7:0]  ady;
  logic [13:0] rem;
  logic        neg;
  logic [7:0]  root;
  logic [2:0]  cnt;

  logic [6:0]  r_eff;
  logic [7:0]  r8;
  logic [7:0]  span;
  logic [7:0]  adx;
  logic        last;
  logic        col_end;
  logic [15:0] dd;
  logic [7:0]  trial;
  logic [15:0] trial_sq;
  logic [15:0] root_sq;
  logic [15:0] excess;
  logic [7:0]  rs8;

  assign r_eff   = (radius > 7'(MAX_RADIUS)) ? 7'(MAX_RADIUS) : radius;
  assign r8      = {1'b0, r_eff};
  assign span    = {r_eff, 1'b0};
  assign adx     = (col >= r8) ? col - r8 : r8 - col;
  assign col_end = (col >= span);
  assign last    = (row >= span) && col_end;
  assign rs8     = {1'b0, rs};
  assign dd      = ady * ady;
  assign trial   = root | (8'd1 << cnt);
  assign trial_sq = trial * trial;
  assign root_sq = root * root;
  assign excess  = {2'b00, rem} - root_sq;

  assign status.start    = req_start;
  assign status.cnt_more = (cnt != 3'd0);
  assign status.out_busy = out_valid;
  assign status.row_end  = !last && col_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr_x      <= '0;
      ctr_y      <= '0;
      radius     <= '0;
      fg_color   <= '0;
      back_color <= '0;
      row       <= '0;
      col       <= '0;
      half_width <= '0;
      done      <= 1'b1;
      req_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CTR_X:      ctr_x      <= cfg_data[7:0];
          REG_CTR_Y:      ctr_y      <= cfg_data[7:0];
          REG_RADIUS:     radius     <= cfg_data[6:0];
          REG_FG_COLOR:   fg_color   <= cfg_data;
          REG_BACK_COLOR: back_color <= cfg_data;
          default: ;
        endcase
      end

      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end

      case (act)
        A_ACCEPT: begin
          if (in_valid) begin
            req_start <= restart | done;
          end
        end
        A_START: begin
          row  <= '0;
          col  <= '0;
          done <= 1'b0;
        end
        A_ROUND: begin
          if (neg) begin
            half_width <= '0;
          end else if (excess > {8'd0, root}) begin
            half_width <= root + 8'd1;
          end else begin
            half_width <= root;
          end
        end
        A_EMIT: begin
          out_valid <= 1'b1;
          req_start <= 1'b0;
          if (last) begin
            done <= 1'b1;
          end else if (col_end) begin
            col <= '0;
            row <= row + 8'd1;
          end else begin
            col <= col + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Payload registers of the root unit and the output word
  always_ff @(posedge clk) begin
    case (act)
      A_START: begin
        rs <= r_eff;
      end
      A_SQR: begin
        rr  <= 14'(rs * rs);
        ady <= (row >= rs8) ? row - rs8 : rs8 - row;
      end
      A_DIFF: begin
        neg  <= (dd > {2'b00, rr});
        rem  <= 14'({2'b00, rr} - dd);
        root <= '0;
        cnt  <= 3'd7;
      end
      A_ROOT: begin
        if (trial_sq <= {2'b00, rem}) begin
          root <= trial;
        end
        cnt <= cnt - 3'd1;
      end
      A_EMIT: begin
        rs          <= r_eff;
        pixel_x     <= ctr_x - r8 + col;
        pixel_y     <= ctr_y - r8 + row;
        pixel_color <= (adx < half_width) ? fg_color : back_color;
        last_pixel  <= last;
      end
      default: ;
    endcase
  end

endmodule

[design/filled_circle_pixel_generator.sv]
// Top level of the filled circle pixel generator.
//
// Streams the pixels of a (2r+1) by (2r+1) window around (ctr_x, ctr_y)
// in row-major order, one output word for each input word.
// s_tdata[0] is the restart flag: 1 begins a new window at its top-left
// pixel, 0 advances one pixel (or begins a new window when none is active).
// m_tdata carries pixel_x, pixel_y and pixel_color; m_tlast marks the
// bottom-right pixel of the window.
// The cfg channel writes ctr_x, ctr_y, radius, fg_color and back_color
// (indexes 0 to 4); it is always ready. The user must write it only while
// idle; the block itself does not enforce this. A short microcode program
// sequences a plain datapath. A word inside a row passes from acceptance
// through dispatch and the output wait to the emit step, which sets m_tvalid.
// The first word of a window runs the half-width root before its emit step,
// and a row end runs it after, holding s_tready low: one square, one square
// difference, 8 bit-serial root steps and a rounding step.
// s_tready is high only when the sequencer rests in its idle step.
// A stalled m_tready holds the output word; the next input word is still
// accepted and waits at the output step until the register frees.
// Reset clears the configuration to zero and leaves no window active.
module filled_circle_pixel_generator #(
  parameter int MAX_RADIUS = fcpg_pkg::MAX_RADIUS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Input words
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [0] restart, rest zero
  // Output words
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [31:0]                     m_tdata,   // [7:0] pixel_x, [15:8] pixel_y,
                                                     // [31:16] pixel_color
  output logic                            m_tlast,   // last_pixel
  // Configuration writes
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [fcpg_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fcpg_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fcpg_pkg::*;

  act_e        act;
  status_t     status;
  logic        idle;
  logic [7:0]  pixel_x;
  logic [7:0]  pixel_y;
  logic [15:0] pixel_color;

  assign cfg_ready = 1'b1;
  assign s_tready  = idle;
  assign m_tdata   = {pixel_color, pixel_y, pixel_x};

  // Step counter and control word fetch
  fcpg_seq u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .status   (status),
    .act      (act),
    .idle     (idle)
  );

  // Offsets, root unit and output register
  fcpg_datapath #(
    .MAX_RADIUS (MAX_RADIUS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .act         (act),
    .cfg_we      (cfg_valid),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_valid    (s_tvalid),
    .restart     (s_tdata[0]),
    .out_ready   (m_tready),
    .out_valid   (m_tvalid),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .last_pixel  (m_tlast),
    .status      (status)
  );

endmodule

[design/fcpg_checker.sv]
// Port-level checker for the filled circle pixel generator, with its bind.
module fcpg_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata,
  input logic        m_tlast
);

  // Hold a stalled output word
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("output word changed while stalled");

  // One input word in flight at a time
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input accepted twice in a row");

  // A new output word appears only while the sequencer is busy
  a_out_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !s_tready)
    else $error("output word appeared with sequencer idle");

  // Reset leaves no output word pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid after reset");

endmodule

bind filled_circle_pixel_generator fcpg_checker u_fcpg_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tlast  (m_tlast)
);
